// ===== rtl/core/pfm_pkg.sv =====
// ---------------------------------------------------------------------------
// pfm_pkg
// Shared types, codes and defaults of the packet flow meter.
// ---------------------------------------------------------------------------
`default_nettype none

package pfm_pkg;

    localparam int DEF_FLOW_ENTRIES  = 256;
    localparam int DEF_CAPTURE_LIMIT = 128;

    localparam logic [16:0] POS_MAX = 17'h1FFFF;

    localparam logic [1:0] ST_RECORDED  = 2'd0;
    localparam logic [1:0] ST_NOT_IPV4  = 2'd1;
    localparam logic [1:0] ST_BAD_HDR   = 2'd2;

    localparam logic [7:0]  PROTO_ICMP    = 8'd1;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [15:0] ETHERTYPE_IP4 = 16'h0800;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        frame_end;
        logic [63:0] arrival_time;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [7:0]  protocol_number;
        logic [5:0]  tcp_flag_bits;
        logic [15:0] ip_total_length;
        logic [7:0]  captured_payload_length;
        logic        flow_is_new;
        logic [63:0] flow_packets;
        logic [63:0] flow_bytes;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] addresses;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [7:0]  protocol;
        logic [5:0]  flags;
        logic [15:0] total_length;
        logic [7:0]  payload_length;
    } parse_t;

    typedef struct packed {
        logic in_ready;
        logic scan_start;
        logic scan_run;
        logic slot_read;
        logic write_entry;
        logic emit_error;
    } ctrl_cmd_t;

    typedef struct packed {
        logic end_xfer;
        logic parse_ok;
        logic scan_last;
        logic out_free;
    } ctrl_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/pfm_parser.sv =====
// ---------------------------------------------------------------------------
// pfm_parser
// Captures header fields byte by byte and checks the frame at its end.
// ---------------------------------------------------------------------------
`default_nettype none

module pfm_parser
    import pfm_pkg::*;
#(
    parameter int CAPTURE_LIMIT = DEF_CAPTURE_LIMIT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     xfer,
    input  wire in_item_t item,
    output parse_t        result
);

    logic [16:0] pos_reg;
    logic [15:0] eth_reg, eth_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [15:0] tot_reg, tot_next;
    logic [7:0]  proto_reg, proto_next;
    logic [63:0] addr_reg, addr_next;
    logic [31:0] ports_reg, ports_next;
    logic [15:0] udp_reg, udp_next;
    logic [3:0]  doff_reg, doff_next;
    logic [5:0]  flags_reg, flags_next;

    logic [17:0] f_len_reg;
    logic [15:0] f_eth_reg;
    logic [3:0]  f_ihl_reg;
    logic [15:0] f_tot_reg;
    logic [7:0]  f_proto_reg;
    logic [63:0] f_addr_reg;
    logic [31:0] f_ports_reg;
    logic [15:0] f_udp_reg;
    logic [3:0]  f_doff_reg;
    logic [5:0]  f_flags_reg;

    logic [16:0] tstart;
    logic [16:0] off;
    logic [7:0]  b;

    always_comb
    begin
        b          = item.frame_byte;
        eth_next   = eth_reg;
        ihl_next   = ihl_reg;
        tot_next   = tot_reg;
        proto_next = proto_reg;
        addr_next  = addr_reg;
        ports_next = ports_reg;
        udp_next   = udp_reg;
        doff_next  = doff_reg;
        flags_next = flags_reg;
        tstart     = 17'd14 + {11'd0, ihl_reg, 2'b00};
        off        = pos_reg - tstart;
        priority if (pos_reg == 17'd12)
            eth_next = {b, 8'd0};
        else if (pos_reg == 17'd13)
            eth_next = {eth_reg[15:8], b};
        else if (pos_reg == 17'd14)
            ihl_next = b[3:0];
        else if (pos_reg == 17'd16)
            tot_next = {b, 8'd0};
        else if (pos_reg == 17'd17)
            tot_next = {tot_reg[15:8], b};
        else if (pos_reg == 17'd23)
            proto_next = b;
        else if (pos_reg >= 17'd26 && pos_reg <= 17'd33)
            addr_next = {addr_reg[55:0], b};
        if (ihl_reg >= 4'd5 && pos_reg >= 17'd34 && pos_reg >= tstart)
        begin
            priority if (off <= 17'd3)
                ports_next = {ports_reg[23:0], b};
            else if (off == 17'd4)
                udp_next = {b, 8'd0};
            else if (off == 17'd5)
                udp_next = {udp_reg[15:8], b};
            else if (off == 17'd12)
                doff_next = b[7:4];
            else if (off == 17'd13)
                flags_next = b[5:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            eth_reg   <= '0;
            ihl_reg   <= '0;
            tot_reg   <= '0;
            proto_reg <= '0;
            addr_reg  <= '0;
            ports_reg <= '0;
            udp_reg   <= '0;
            doff_reg  <= '0;
            flags_reg <= '0;
        end
        else if (xfer)
        begin
            if (item.frame_end)
            begin
                pos_reg   <= '0;
                eth_reg   <= '0;
                ihl_reg   <= '0;
                tot_reg   <= '0;
                proto_reg <= '0;
                addr_reg  <= '0;
                ports_reg <= '0;
                udp_reg   <= '0;
                doff_reg  <= '0;
                flags_reg <= '0;
            end
            else
            begin
                if (pos_reg != POS_MAX)
                    pos_reg <= pos_reg + 17'd1;
                eth_reg   <= eth_next;
                ihl_reg   <= ihl_next;
                tot_reg   <= tot_next;
                proto_reg <= proto_next;
                addr_reg  <= addr_next;
                ports_reg <= ports_next;
                udp_reg   <= udp_next;
                doff_reg  <= doff_next;
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (xfer && item.frame_end)
        begin
            f_len_reg   <= {1'b0, pos_reg} + 18'd1;
            f_eth_reg   <= eth_next;
            f_ihl_reg   <= ihl_next;
            f_tot_reg   <= tot_next;
            f_proto_reg <= proto_next;
            f_addr_reg  <= addr_next;
            f_ports_reg <= ports_next;
            f_udp_reg   <= udp_next;
            f_doff_reg  <= doff_next;
            f_flags_reg <= flags_next;
        end
    end

    logic [17:0] t18;
    logic [6:0]  poff;
    logic [15:0] p;
    logic [15:0] pclip;
    logic [17:0] pend;
    logic        has_payload;

    always_comb
    begin
        result         = '0;
        t18            = 18'd14 + {12'd0, f_ihl_reg, 2'b00};
        poff           = '0;
        p              = '0;
        has_payload    = 1'b0;
        result.status  = ST_RECORDED;
        if (f_len_reg < 18'd14 || f_eth_reg != ETHERTYPE_IP4)
            result.status = ST_NOT_IPV4;
        else if (f_len_reg < 18'd34 || f_ihl_reg < 4'd5 || t18 > f_len_reg)
            result.status = ST_BAD_HDR;
        else if (f_proto_reg == PROTO_TCP)
        begin
            if (t18 + 18'd20 > f_len_reg)
                result.status = ST_BAD_HDR;
            poff        = {1'b0, f_ihl_reg, 2'b00} + {1'b0, f_doff_reg, 2'b00};
            p           = f_tot_reg - {9'd0, poff};
            has_payload = 1'b1;
        end
        else if (f_proto_reg == PROTO_UDP)
        begin
            if (t18 + 18'd8 > f_len_reg)
                result.status = ST_BAD_HDR;
            poff        = {1'b0, f_ihl_reg, 2'b00} + 7'd8;
            p           = f_udp_reg - 16'd8;
            has_payload = 1'b1;
        end
        else if (f_proto_reg == PROTO_ICMP)
        begin
            if (t18 + 18'd8 > f_len_reg)
                result.status = ST_BAD_HDR;
        end
        else
            result.status = ST_BAD_HDR;

        pclip = (p > 16'(CAPTURE_LIMIT)) ? 16'(CAPTURE_LIMIT) : p;
        pend  = 18'd14 + {11'd0, poff} + {2'b00, pclip};

        if (result.status == ST_RECORDED)
        begin
            result.addresses    = f_addr_reg;
            result.protocol     = f_proto_reg;
            result.total_length = f_tot_reg;
            if (f_proto_reg != PROTO_ICMP)
            begin
                result.source_port      = f_ports_reg[31:16];
                result.destination_port = f_ports_reg[15:0];
            end
            if (f_proto_reg == PROTO_TCP)
                result.flags = f_flags_reg;
            if (has_payload && pend <= f_len_reg)
                result.payload_length = pclip[7:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pfm_ctrl.sv =====
// ---------------------------------------------------------------------------
// pfm_ctrl
// Sequences byte intake, flow table scan, update and record emission.
// ---------------------------------------------------------------------------
`default_nettype none

module pfm_ctrl
    import pfm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ctrl_stat_t stat,
    output ctrl_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.end_xfer)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (!stat.parse_ok)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit_error = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
                state_next = S_READ;
            S_READ:
            begin
                cmd.slot_read = 1'b1;
                state_next    = S_WRITE;
            end
            S_WRITE:
            begin
                if (stat.out_free)
                begin
                    cmd.write_entry = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/pfm_table.sv =====
// ---------------------------------------------------------------------------
// pfm_table
// Flow table memories, LRU search, entry update and the record register.
// ---------------------------------------------------------------------------
`default_nettype none

module pfm_table
    import pfm_pkg::*;
#(
    parameter int FLOW_ENTRIES = DEF_FLOW_ENTRIES
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire ctrl_cmd_t cmd,
    input  wire parse_t    pr,
    input  wire logic      record_ready,
    output logic           scan_last,
    output logic           out_free,
    output logic           record_valid,
    output out_item_t      record_data
);

    localparam int IW = $clog2(FLOW_ENTRIES);

    logic [103:0] key_mem [FLOW_ENTRIES];
    logic [31:0]  rec_mem [FLOW_ENTRIES];
    logic [133:0] cnt_mem [FLOW_ENTRIES];

    logic [103:0] key_rd_reg;
    logic [31:0]  rec_rd_reg;
    logic [133:0] cnt_rd_reg;

    logic [IW-1:0] scan_idx_reg;
    logic [IW-1:0] cmp_idx_reg;
    logic          cmp_valid_reg;
    logic          found_reg;
    logic [IW-1:0] match_idx_reg;
    logic [31:0]   best_age_reg;
    logic [IW-1:0] best_idx_reg;
    logic [IW:0]   fill_reg;
    logic [31:0]   clock_reg;
    logic [IW-1:0] slot_reg;
    logic          new_reg;

    logic          out_valid_reg;
    out_item_t     out_reg;

    logic [103:0]  key;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] slot;
    logic [31:0]   age;
    logic          in_use;
    logic [63:0]   pk;
    logic [63:0]   by;
    logic [5:0]    fl;

    assign key       = {pr.addresses, pr.source_port, pr.destination_port, pr.protocol};
    assign scan_last = (scan_idx_reg == IW'(FLOW_ENTRIES - 1));
    assign out_free  = !out_valid_reg || record_ready;
    assign age       = clock_reg - rec_rd_reg;
    assign in_use    = ({1'b0, cmp_idx_reg} < fill_reg);

    always_comb
    begin
        priority if (found_reg)
            slot = match_idx_reg;
        else if (fill_reg < (IW+1)'(FLOW_ENTRIES))
            slot = fill_reg[IW-1:0];
        else
            slot = best_idx_reg;
    end

    assign rd_addr = cmd.slot_read ? slot : scan_idx_reg;

    always_comb
    begin
        if (new_reg)
        begin
            pk = 64'd1;
            by = {48'd0, pr.total_length};
            fl = pr.flags;
        end
        else
        begin
            pk = cnt_rd_reg[133:70] + 64'd1;
            by = cnt_rd_reg[69:6] + {48'd0, pr.total_length};
            fl = cnt_rd_reg[5:0] | pr.flags;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_run || cmd.slot_read)
        begin
            key_rd_reg <= key_mem[rd_addr];
            rec_rd_reg <= rec_mem[rd_addr];
            cnt_rd_reg <= cnt_mem[rd_addr];
        end
        if (cmd.write_entry)
        begin
            if (new_reg)
                key_mem[slot_reg] <= key;
            rec_mem[slot_reg] <= clock_reg;
            cnt_mem[slot_reg] <= {pk, by, fl};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            cmp_idx_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            match_idx_reg <= '0;
            best_age_reg  <= '0;
            best_idx_reg  <= '0;
            fill_reg      <= '0;
            clock_reg     <= '0;
            slot_reg      <= '0;
            new_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.scan_run;
            cmp_idx_reg   <= scan_idx_reg;
            if (cmd.scan_start)
            begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
                best_age_reg <= '0;
                best_idx_reg <= '0;
            end
            else if (cmd.scan_run)
                scan_idx_reg <= scan_idx_reg + IW'(1);

            if (cmp_valid_reg && in_use)
            begin
                if (!found_reg && key_rd_reg == key)
                begin
                    found_reg     <= 1'b1;
                    match_idx_reg <= cmp_idx_reg;
                end
                if (cmp_idx_reg == '0 || age > best_age_reg)
                begin
                    best_age_reg <= age;
                    best_idx_reg <= cmp_idx_reg;
                end
            end

            if (cmd.slot_read)
            begin
                slot_reg <= slot;
                new_reg  <= !found_reg;
            end

            if (cmd.write_entry)
            begin
                clock_reg <= clock_reg + 32'd1;
                if (new_reg && fill_reg < (IW+1)'(FLOW_ENTRIES))
                    fill_reg <= fill_reg + (IW+1)'(1);
            end

            if (cmd.write_entry || cmd.emit_error)
                out_valid_reg <= 1'b1;
            else if (record_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_error)
        begin
            out_reg <= {pr.status, {($bits(out_item_t) - 2){1'b0}}};
        end
        else if (cmd.write_entry)
        begin
            out_reg.status                  <= ST_RECORDED;
            out_reg.source_address          <= pr.addresses[63:32];
            out_reg.destination_address     <= pr.addresses[31:0];
            out_reg.source_port             <= pr.source_port;
            out_reg.destination_port        <= pr.destination_port;
            out_reg.protocol_number         <= pr.protocol;
            out_reg.tcp_flag_bits           <= pr.flags;
            out_reg.ip_total_length         <= pr.total_length;
            out_reg.captured_payload_length <= pr.payload_length;
            out_reg.flow_is_new             <= new_reg;
            out_reg.flow_packets            <= pk;
            out_reg.flow_bytes              <= by;
        end
    end

    assign record_valid = out_valid_reg;
    assign record_data  = out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/packet_flow_meter.sv =====
// ---------------------------------------------------------------------------
// packet_flow_meter
// IPv4 five-tuple flow meter with a least-recently-used flow table.
//
//   channel  | handshake                   | payload
//   frame    | frame_valid / frame_ready   | frame_data  (in_item_t)
//   record   | record_valid / record_ready | record_data (out_item_t)
//
// Bytes inside a frame take one cycle each.
// After the final byte the block scans the whole flow table memory, one
// entry per cycle, then reads and writes the chosen slot.
// A frame with a bad header skips the scan and gets an error record.
// Reset clears the table by zeroing the fill count; no clearing pass.
// A waiting record stalls the block only when the next record is ready.
// ---------------------------------------------------------------------------
`default_nettype none

module packet_flow_meter
    import pfm_pkg::*;
#(
    parameter int FLOW_ENTRIES  = DEF_FLOW_ENTRIES,
    parameter int CAPTURE_LIMIT = DEF_CAPTURE_LIMIT
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      frame_valid,
    output logic           frame_ready,
    input  wire in_item_t  frame_data,
    output logic           record_valid,
    input  wire logic      record_ready,
    output out_item_t      record_data
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;
    parse_t     pr;
    logic       xfer;
    logic       scan_last;
    logic       out_free;

    assign frame_ready    = cmd.in_ready;
    assign xfer           = frame_valid && frame_ready;
    assign stat.end_xfer  = xfer && frame_data.frame_end;
    assign stat.parse_ok  = (pr.status == ST_RECORDED);
    assign stat.scan_last = scan_last;
    assign stat.out_free  = out_free;

    pfm_parser #(
        .CAPTURE_LIMIT (CAPTURE_LIMIT)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .xfer   (xfer),
        .item   (frame_data),
        .result (pr)
    );

    pfm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    pfm_table #(
        .FLOW_ENTRIES (FLOW_ENTRIES)
    ) u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .pr           (pr),
        .record_ready (record_ready),
        .scan_last    (scan_last),
        .out_free     (out_free),
        .record_valid (record_valid),
        .record_data  (record_data)
    );

    a_end_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && frame_ready && frame_data.frame_end) |=> !frame_ready)
        else $error("frame accepted right after final byte");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid |-> (record_data.status != 2'd3))
        else $error("record status out of range");

    a_error_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (record_valid && record_data.status != ST_RECORDED) |->
        (record_data.flow_packets == 64'd0 && record_data.flow_is_new == 1'b0))
        else $error("error record carries flow data");

    a_new_first: assert property (@(posedge clk) disable iff (!rst_n)
        (record_valid && record_data.status == ST_RECORDED && record_data.flow_is_new)
        |-> (record_data.flow_packets == 64'd1))
        else $error("new flow with packet count other than one");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Frame-level check of packet_flow_meter.
// Frames are built byte by byte (Ethernet, IPv4, TCP/UDP/ICMP, noise) and
// streamed into the frame channel. A software flow table tracks every frame
// and predicts the status record; records are compared as a whole, in
// order. Sender and receiver idle at random over several phases.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
    import pfm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SIZE  = 256;
    localparam int CAP_LIMIT   = 128;
    localparam int CYCLE_LIMIT = 2000000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       frame_valid = 1'b0;
    logic       frame_ready;
    in_item_t   frame_data = '0;
    logic       record_valid;
    logic       record_ready = 1'b0;
    out_item_t  record_data;

    packet_flow_meter dut (
        .clk(clk), .rst_n(rst_n),
        .frame_valid(frame_valid), .frame_ready(frame_ready), .frame_data(frame_data),
        .record_valid(record_valid), .record_ready(record_ready),
        .record_data(record_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // meter model state
    logic [16:0] m_pos;
    logic [15:0] m_ethertype, m_total_len, m_udp_len;
    logic [3:0]  m_ihl, m_doff;
    logic [7:0]  m_proto;
    logic [63:0] m_addr;
    logic [31:0] m_ports;
    logic [5:0]  m_flags;
    logic        fl_valid [TABLE_SIZE];
    logic [63:0] fl_addr [TABLE_SIZE];
    logic [39:0] fl_key [TABLE_SIZE];
    logic [63:0] fl_pkts [TABLE_SIZE];
    logic [63:0] fl_bytes [TABLE_SIZE];
    logic [31:0] fl_stamp [TABLE_SIZE];
    logic [31:0] lru_clock;

    in_item_t   byte_queue[$];
    out_item_t  expected_records[$];
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    bit         send_hold = 1'b0;
    int         errors = 0;
    int         records_seen = 0;
    int         bytes_sent = 0;
    int         new_flows = 0;
    longint     cycles = 0;

    task automatic clear_capture();
        m_pos = '0; m_ethertype = '0; m_ihl = '0; m_total_len = '0; m_proto = '0;
        m_addr = '0; m_ports = '0; m_flags = '0; m_doff = '0; m_udp_len = '0;
    endtask

    function automatic logic [1:0] check_headers(input int unsigned len,
            output logic [15:0] sp, output logic [15:0] dp, output logic [5:0] fl,
            output logic [7:0] plen);
        int unsigned t, poff, p;
        sp = m_ports[31:16]; dp = m_ports[15:0]; fl = '0; plen = '0;
        if (len < 14 || m_ethertype != ETHERTYPE_IP4) return ST_NOT_IPV4;
        if (len < 34 || m_ihl < 5) return ST_BAD_HDR;
        t = 14 + 4 * m_ihl;
        if (t > len) return ST_BAD_HDR;
        if (m_proto == PROTO_TCP) begin
            if (t + 20 > len) return ST_BAD_HDR;
            fl = m_flags;
            poff = 4 * m_ihl + 4 * m_doff;
            p = (m_total_len - poff) & 16'hFFFF;
        end else if (m_proto == PROTO_UDP) begin
            if (t + 8 > len) return ST_BAD_HDR;
            poff = 4 * m_ihl + 8;
            p = (m_udp_len - 8) & 16'hFFFF;
        end else if (m_proto == PROTO_ICMP) begin
            if (t + 8 > len) return ST_BAD_HDR;
            sp = '0; dp = '0;
            return ST_RECORDED;
        end else begin
            return ST_BAD_HDR;
        end
        if (p > CAP_LIMIT) p = CAP_LIMIT;
        plen = (14 + poff + p <= len) ? p[7:0] : 8'd0;
        return ST_RECORDED;
    endfunction

    task automatic meter_byte(input in_item_t it);
        int unsigned pos, t, off;
        logic [7:0]  b;
        logic [15:0] sp, dp;
        logic [5:0]  fl;
        logic [7:0]  plen;
        logic [39:0] key;
        logic [31:0] age, best;
        int          slot;
        bit          found, freeslot;
        out_item_t   rec;
        pos = m_pos; b = it.frame_byte;
        if (pos == 12) m_ethertype = {b, 8'h00};
        else if (pos == 13) m_ethertype[7:0] = b;
        else if (pos == 14) m_ihl = b[3:0];
        else if (pos == 16) m_total_len = {b, 8'h00};
        else if (pos == 17) m_total_len[7:0] = b;
        else if (pos == 23) m_proto = b;
        else if (pos >= 26 && pos <= 33) m_addr = {m_addr[55:0], b};
        if (m_ihl >= 5 && pos >= 34) begin
            t = 14 + 4 * m_ihl;
            if (pos >= t) begin
                off = pos - t;
                if (off <= 3) m_ports = {m_ports[23:0], b};
                else if (off == 4) m_udp_len = {b, 8'h00};
                else if (off == 5) m_udp_len[7:0] = b;
                else if (off == 12) m_doff = b[7:4];
                else if (off == 13) m_flags = b[5:0];
            end
        end
        if (!it.frame_end) begin
            if (m_pos != POS_MAX) m_pos = m_pos + 17'd1;
            return;
        end
        rec = '0;
        rec.status = check_headers(pos + 1, sp, dp, fl, plen);
        if (rec.status == ST_RECORDED) begin
            key = {sp, dp, m_proto};
            found = 0; freeslot = 0; slot = 0;
            for (int i = 0; i < TABLE_SIZE && !found; i++)
                if (fl_valid[i] && fl_addr[i] == m_addr && fl_key[i] == key) begin
                    slot = i; found = 1;
                end
            if (!found) begin
                for (int i = 0; i < TABLE_SIZE && !freeslot; i++)
                    if (!fl_valid[i]) begin
                        slot = i; freeslot = 1;
                    end
                if (!freeslot) begin
                    best = '0;
                    for (int i = 0; i < TABLE_SIZE; i++) begin
                        age = lru_clock - fl_stamp[i];
                        if (i == 0 || age > best) begin
                            best = age; slot = i;
                        end
                    end
                end
                fl_valid[slot] = 1'b1; fl_addr[slot] = m_addr; fl_key[slot] = key;
                fl_pkts[slot] = 64'd1; fl_bytes[slot] = {48'd0, m_total_len};
                new_flows++;
            end else begin
                fl_pkts[slot] += 64'd1;
                fl_bytes[slot] += {48'd0, m_total_len};
            end
            fl_stamp[slot] = lru_clock;
            lru_clock = lru_clock + 32'd1;
            rec.source_address = m_addr[63:32];
            rec.destination_address = m_addr[31:0];
            rec.source_port = sp;
            rec.destination_port = dp;
            rec.protocol_number = m_proto;
            rec.tcp_flag_bits = fl;
            rec.ip_total_length = m_total_len;
            rec.captured_payload_length = plen;
            rec.flow_is_new = !found;
            rec.flow_packets = fl_pkts[slot];
            rec.flow_bytes = fl_bytes[slot];
        end
        expected_records.push_back(rec);
        clear_capture();
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (frame_valid && frame_ready) begin
                meter_byte(frame_data);
                bytes_sent++;
            end
            if (!(frame_valid && !frame_ready)) begin
                if (byte_queue.size() > 0 && !send_hold
                        && $urandom_range(99) >= send_idle_pct) begin
                    frame_valid <= 1'b1;
                    frame_data <= byte_queue.pop_front();
                end else begin
                    frame_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n) begin
            if (record_valid && record_ready) begin
                records_seen++;
                if (expected_records.size() == 0) begin
                    errors++;
                    $display("%0t: record with none expected: %p", $time, record_data);
                end else begin
                    e = expected_records.pop_front();
                    if (record_data !== e) begin
                        errors++;
                        $display("%0t: record mismatch\n  expected %p\n  actual   %p",
                                 $time, e, record_data);
                    end
                end
            end
            record_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // frame builders
    logic [63:0] stamp = 64'd0;
    logic [63:0] flow_pool [16];

    task automatic push_bytes(input logic [7:0] fb[$]);
        in_item_t it;
        foreach (fb[i]) begin
            it.frame_byte = fb[i];
            it.frame_end = (i == fb.size() - 1);
            stamp = stamp + 64'($urandom_range(1, 5000));
            it.arrival_time = ($urandom_range(9) == 0) ? {$urandom, $urandom} : stamp;
            byte_queue.push_back(it);
        end
    endtask

    // proto, ihl, data offset, total length, udp length, addresses, ports, flags,
    // extra tail bytes; trunc cuts the frame to that length when nonzero; etype is the ethertype
    task automatic build_ip(input logic [7:0] proto, input logic [3:0] ihl,
            input logic [3:0] doff, input logic [15:0] tlen, input logic [15:0] ulen,
            input logic [63:0] addr, input logic [31:0] ports, input logic [7:0] flg,
            input int tail, input int trunc, input logic [15:0] etype);
        logic [7:0] fb[$];
        int hdr;
        for (int i = 0; i < 12; i++) fb.push_back(8'($urandom));
        fb.push_back(etype[15:8]); fb.push_back(etype[7:0]);
        fb.push_back({4'h4, ihl}); fb.push_back(8'($urandom));
        fb.push_back(tlen[15:8]); fb.push_back(tlen[7:0]);
        for (int i = 0; i < 5; i++) fb.push_back(8'($urandom));
        fb.push_back(proto); fb.push_back(8'($urandom)); fb.push_back(8'($urandom));
        for (int i = 0; i < 8; i++) fb.push_back(addr[63 - 8*i -: 8]);
        hdr = (ihl < 5 ? 5 : int'(ihl)) * 4;
        for (int i = 20; i < hdr; i++) fb.push_back(8'($urandom));
        for (int i = 0; i < 4; i++) fb.push_back(ports[31 - 8*i -: 8]);
        fb.push_back(ulen[15:8]); fb.push_back(ulen[7:0]);
        for (int i = 6; i < 12; i++) fb.push_back(8'($urandom));
        fb.push_back({doff, 4'($urandom)}); fb.push_back(flg);
        for (int i = 14; i < 20; i++) fb.push_back(8'($urandom));
        for (int i = 0; i < tail; i++) fb.push_back(8'($urandom));
        if (trunc > 0) while (fb.size() > trunc) void'(fb.pop_back());
        push_bytes(fb);
    endtask

    task automatic random_frame(input bit well_formed);
        logic [7:0]  proto;
        logic [3:0]  ihl, doff;
        logic [15:0] tlen, ulen;
        int          k, tail, trunc, noise;
        logic [7:0]  fb[$];
        k = int'($urandom_range(3));
        case ($urandom_range(2))
            0: proto = PROTO_TCP;
            1: proto = PROTO_UDP;
            default: proto = PROTO_ICMP;
        endcase
        ihl = well_formed ? 4'($urandom_range(5, 7)) : 4'($urandom);
        doff = 4'($urandom_range(5, 6));
        tail = int'($urandom_range(0, 16));
        tlen = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(4*ihl + 4*doff + tail);
        ulen = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(8 + tail);
        trunc = 0;
        if (!well_formed) begin
            case ($urandom_range(4))
                0: trunc = int'($urandom_range(1, 60));
                1: proto = 8'($urandom);
                2: begin
                    noise = int'($urandom_range(1, 70));
                    for (int i = 0; i < noise; i++) fb.push_back(8'($urandom));
                    push_bytes(fb);
                    return;
                end
                default: ;
            endcase
        end
        build_ip(proto, ihl, doff, tlen, ulen, flow_pool[k],
                 (proto == PROTO_ICMP) ? $urandom : {16'(k), 16'(k * 3)}, 8'($urandom),
                 tail, trunc, ($urandom_range(30) == 0) ? 16'($urandom) : ETHERTYPE_IP4);
    endtask

    task automatic wait_drained();
        wait (byte_queue.size() == 0 && !frame_valid && expected_records.size() == 0);
        repeat (300) @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] fb[$];
        clear_capture();
        lru_clock = '0;
        foreach (fl_valid[i]) fl_valid[i] = 1'b0;
        foreach (flow_pool[i]) flow_pool[i] = {$urandom, $urandom};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed frames
        build_ip(PROTO_TCP, 4'd5, 4'd5, 16'd60, 16'd0, 64'hFFFFFFFF_00000000,
                 32'hFFFF0000, 8'hFF, 0, 0, ETHERTYPE_IP4);
        build_ip(PROTO_TCP, 4'd5, 4'd5, 16'd60, 16'd0, 64'hFFFFFFFF_00000000,
                 32'hFFFF0000, 8'h00, 0, 0, ETHERTYPE_IP4);
        build_ip(PROTO_TCP, 4'd15, 4'd15, 16'hFFFF, 16'd0, 64'h0, 32'h0, 8'h15, 0, 0,
                 ETHERTYPE_IP4);
        build_ip(PROTO_TCP, 4'd5, 4'd0, 16'd10, 16'd0, 64'h1, 32'h1, 8'h2A, 0, 0,
                 ETHERTYPE_IP4);
        build_ip(PROTO_UDP, 4'd5, 4'd0, 16'd40, 16'd3, 64'h2, 32'h2, 8'h0, 0, 0,
                 ETHERTYPE_IP4);
        build_ip(PROTO_UDP, 4'd5, 4'd0, 16'd40, 16'd136, 64'h2, 32'h2, 8'h0, 128, 0,
                 ETHERTYPE_IP4);
        build_ip(PROTO_ICMP, 4'd6, 4'd0, 16'd28, 16'd0, 64'h3, 32'hABCD1234, 8'h3F, 0, 0,
                 ETHERTYPE_IP4);
        build_ip(PROTO_TCP, 4'd4, 4'd5, 16'd40, 16'd0, 64'h4, 32'h4, 8'h1, 0, 0,
                 ETHERTYPE_IP4);
        build_ip(8'd99, 4'd5, 4'd5, 16'd40, 16'd0, 64'h5, 32'h5, 8'h1, 0, 0,
                 ETHERTYPE_IP4);
        build_ip(PROTO_TCP, 4'd5, 4'd5, 16'd40, 16'd0, 64'h6, 32'h6, 8'h1, 0, 40,
                 ETHERTYPE_IP4);
        build_ip(PROTO_UDP, 4'd5, 4'd5, 16'd40, 16'd8, 64'h7, 32'h7, 8'h1, 0, 30,
                 16'h86DD);
        fb = {8'hAA};
        push_bytes(fb);
        fb = {};
        for (int i = 0; i < 13; i++) fb.push_back(8'h08);
        push_bytes(fb);
        wait_drained();

        // sender pauses until every record is back
        send_hold = 1'b1;
        for (int i = 0; i < 2; i++) random_frame(1'b1);
        send_hold = 1'b0;
        wait (byte_queue.size() == 0);
        send_hold = 1'b1;
        wait (expected_records.size() == 0 && !frame_valid);
        send_hold = 1'b0;

        // random phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            for (int f = 0; f < 3; f++) begin
                if ($urandom_range(4) == 0)
                    random_frame(1'b0);
                else
                    random_frame(1'b1);
                if (f == 0) foreach (flow_pool[i])
                    if ($urandom_range(7) == 0) flow_pool[i] = {$urandom, $urandom};
            end
            wait_drained();
        end

        $display("sent %0d bytes, checked %0d records, %0d new flows created",
                 bytes_sent, records_seen, new_flows);
        if (errors == 0 && expected_records.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
